// ----- design/ctr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctr_pkg
// Shared types and constants for the constant-period trajectory resampler.
// ----------------------------------------------------------------------------
package ctr_pkg;

  localparam int unsigned MAX_SAMPLES = 64;
  localparam int unsigned IDX_W = 7;
  localparam logic [31:0] PERIOD_RESET = 32'h0001_0000;

  typedef enum logic {
    STATUS_OK       = 1'b0,
    STATUS_OVERFLOW = 1'b1
  } status_t;

  typedef struct packed {
    logic [31:0]        point_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_heading;
    logic signed [31:0] point_lin_speed;
    logic signed [31:0] point_ang_speed;
    logic               final_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   sample_index;
    logic [31:0]        sample_time;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] sample_heading;
    logic signed [31:0] sample_lin_speed;
    logic signed [31:0] sample_ang_speed;
    status_t            status_code;
    logic               run_end;
    logic               trajectory_end;
  } out_item_t;

endpackage

// ----- design/constant_period_trajectory_resampler_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// constant_period_trajectory_resampler_core
// Resamples trajectory points onto a fixed time grid by linear interpolation.
// ----------------------------------------------------------------------------
// One point is taken at a time. Each interpolated sample runs through the
// grid check, the bit-serial restoring divider that gives the 32-bit fraction,
// the shared 32x32 multiplier for each of the 5 fields, a step that forms the
// next grid time (it decides run_end) and the load of the output register. A
// sample copied from the previous point skips the divide and the multiplies.
// The grid time is built with the same multiplier (period times index) in the
// cycle after the transfer. A stalled output register holds the sequencer until
// it frees up. in_stall stays high until every result of the current point has
// been transferred.
module constant_period_trajectory_resampler_core
  import ctr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_GRID, S_GCHK, S_DIV, S_FLD, S_ACC, S_LOOK, S_EMIT, S_FIN, S_DONE
  } state_t;

  state_t            state_r;
  logic [31:0]       period_r;
  logic [31:0]       prev_time_r;
  logic signed [31:0] prev_v_r [5];
  logic [IDX_W-1:0]  count_r;
  logic              started_r;
  in_item_t          cur_r;
  logic [63:0]       grid_r;
  logic [63:0]       nxt_grid_r;
  logic              more_r;
  // divider
  logic [63:0]       rem_r;
  logic [31:0]       quo_r;
  logic [31:0]       den_r;
  logic [5:0]        dstep_r;
  logic [2:0]        fld_r;
  logic              copy_r;
  logic [63:0]       prod_r;
  logic signed [31:0] res_r [5];
  logic              out_valid_r;
  out_item_t         out_r;

  logic [IDX_W-1:0] count_inc;
  assign count_inc = count_r + IDX_W'(1);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  logic signed [31:0] v1_sel, v0_sel;
  logic signed [32:0] diff;
  logic        [31:0] mag;
  always_comb begin
    unique case (fld_r)
      3'd0: v1_sel = cur_r.point_x;
      3'd1: v1_sel = cur_r.point_y;
      3'd2: v1_sel = cur_r.point_heading;
      3'd3: v1_sel = cur_r.point_lin_speed;
      default: v1_sel = cur_r.point_ang_speed;
    endcase
    v0_sel = prev_v_r[fld_r];
    diff = {v1_sel[31], v1_sel} - {v0_sel[31], v0_sel};
    mag = diff[32] ? 32'(-diff) : diff[31:0];
    if (state_r == S_GRID) begin
      mul_a = period_r;
      mul_b = {{(32-IDX_W){1'b0}}, count_r};
    end else if (state_r == S_LOOK) begin
      mul_a = period_r;
      mul_b = {{(32-IDX_W){1'b0}}, count_inc};
    end else begin
      mul_a = mag;
      mul_b = quo_r;
    end
  end

  logic [64:0] trial;
  assign trial = {rem_r, 1'b0} - {1'b0, den_r, 32'd0};

  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  wire accept  = in_valid && !in_stall;
  wire out_go  = out_valid_r && !out_stall;
  wire out_load = (state_r == S_IDLE && accept && !started_r) ||
                  ((state_r == S_EMIT || state_r == S_FIN) && (!out_valid_r || out_go));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      prev_time_r <= '0;
      for (int i = 0; i < 5; i++) prev_v_r[i] <= '0;
      count_r     <= '0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) period_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_go) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept) begin
          cur_r <= in_data;
          if (!started_r) begin
            out_r <= '{sample_index: '0, sample_time: in_data.point_time,
                       sample_x: in_data.point_x, sample_y: in_data.point_y,
                       sample_heading: in_data.point_heading,
                       sample_lin_speed: in_data.point_lin_speed,
                       sample_ang_speed: in_data.point_ang_speed,
                       status_code: STATUS_OK, run_end: !in_data.final_point,
                       trajectory_end: 1'b0};
            started_r   <= 1'b1;
            count_r     <= IDX_W'(1);
            state_r     <= S_DONE;
          end else begin
            state_r <= S_GRID;
          end
        end
        S_GRID: begin
          grid_r  <= mul_p;
          state_r <= S_GCHK;
        end
        S_GCHK: begin
          if (count_r < IDX_W'(MAX_SAMPLES) && {32'd0, cur_r.point_time} > grid_r) begin
            if (grid_r[31:0] <= prev_time_r || cur_r.point_time <= prev_time_r) begin
              copy_r  <= 1'b1;
              state_r <= S_LOOK;
            end else begin
              copy_r  <= 1'b0;
              rem_r   <= {grid_r[31:0] - prev_time_r, 32'd0};
              den_r   <= cur_r.point_time - prev_time_r;
              quo_r   <= '0;
              dstep_r <= '0;
              state_r <= S_DIV;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle over the 64-bit dividend e << 32
          if (!trial[64]) begin
            rem_r <= trial[63:0];
            quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[62:0], 1'b0};
            quo_r <= {quo_r[30:0], 1'b0};
          end
          dstep_r <= dstep_r + 6'd1;
          if (dstep_r == 6'd31) begin
            fld_r   <= '0;
            state_r <= S_FLD;
          end
        end
        S_FLD: begin
          prod_r  <= mul_p;
          state_r <= S_ACC;
        end
        S_ACC: begin
          res_r[fld_r] <= diff[32] ? v0_sel - $signed(prod_r[63:32])
                                   : v0_sel + $signed(prod_r[63:32]);
          if (fld_r == 3'd4) state_r <= S_LOOK;
          else begin
            fld_r   <= fld_r + 3'd1;
            state_r <= S_FLD;
          end
        end
        S_LOOK: begin
          // next grid time tells whether this sample is the point's last
          nxt_grid_r <= mul_p;
          more_r     <= (count_inc < IDX_W'(MAX_SAMPLES)) &&
                        ({32'd0, cur_r.point_time} > mul_p);
          state_r    <= S_EMIT;
        end
        S_EMIT: if (!out_valid_r || out_go) begin
          out_r.sample_index   <= count_r;
          out_r.sample_time    <= grid_r[31:0];
          out_r.sample_x       <= copy_r ? prev_v_r[0] : res_r[0];
          out_r.sample_y       <= copy_r ? prev_v_r[1] : res_r[1];
          out_r.sample_heading <= copy_r ? prev_v_r[2] : res_r[2];
          out_r.sample_lin_speed <= copy_r ? prev_v_r[3] : res_r[3];
          out_r.sample_ang_speed <= copy_r ? prev_v_r[4] : res_r[4];
          out_r.status_code    <= STATUS_OK;
          out_r.trajectory_end <= 1'b0;
          // a final point always adds its own result, or an overflow record, after the samples
          out_r.run_end        <= !cur_r.final_point && !more_r;
          count_r     <= count_inc;
          grid_r      <= nxt_grid_r;
          state_r     <= S_GCHK;
        end
        S_DONE: if (!out_valid_r || out_go) begin
          // all samples of this point have gone or are in the output register
          prev_time_r <= cur_r.point_time;
          prev_v_r[0] <= cur_r.point_x;
          prev_v_r[1] <= cur_r.point_y;
          prev_v_r[2] <= cur_r.point_heading;
          prev_v_r[3] <= cur_r.point_lin_speed;
          prev_v_r[4] <= cur_r.point_ang_speed;
          state_r <= cur_r.final_point ? S_FIN : S_IDLE;
        end
        S_FIN: if (!out_valid_r || out_go) begin
          if (count_r >= IDX_W'(MAX_SAMPLES)) begin
            out_r <= '{sample_index: '0, sample_time: '0, sample_x: '0,
                       sample_y: '0, sample_heading: '0, sample_lin_speed: '0,
                       sample_ang_speed: '0, status_code: STATUS_OVERFLOW,
                       run_end: 1'b1, trajectory_end: 1'b1};
          end else begin
            out_r <= '{sample_index: count_r, sample_time: cur_r.point_time,
                       sample_x: cur_r.point_x, sample_y: cur_r.point_y,
                       sample_heading: cur_r.point_heading,
                       sample_lin_speed: cur_r.point_lin_speed,
                       sample_ang_speed: cur_r.point_ang_speed,
                       status_code: STATUS_OK, run_end: 1'b1,
                       trajectory_end: 1'b1};
          end
          started_r   <= 1'b0;
          count_r     <= '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the trajectory resampler core. A directed table of points
// (field extremes, equal and earlier times, single-point trajectories,
// sample limit overflow) is followed by random trajectories over several
// grid periods. Each accepted point is run through an in-bench model of the
// resampler; transferred samples are compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import ctr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct {
    in_item_t  pt;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_stall = 1'b0;
  logic      out_valid;
  out_item_t out_data;

  constant_period_trajectory_resampler_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // resampler model state
  logic [31:0]        grid_period;
  logic [31:0]        last_time;
  logic signed [31:0] last_vals [5];
  int unsigned        n_samples;
  bit                 in_traj;

  out_item_t expected_samples [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** constant_period_trajectory_resampler_core: FAILED **");
      $finish;
    end
  end

  function automatic out_item_t make_sample(int unsigned idx, logic [31:0] t,
                                            logic signed [31:0] v [5]);
    out_item_t s;
    s = '0;
    s.sample_index     = idx[IDX_W-1:0];
    s.sample_time      = t;
    s.sample_x         = v[0];
    s.sample_y         = v[1];
    s.sample_heading   = v[2];
    s.sample_lin_speed = v[3];
    s.sample_ang_speed = v[4];
    s.status_code      = STATUS_OK;
    return s;
  endfunction

  function automatic out_item_t copy_of(in_item_t p, int unsigned idx, bit re, bit te);
    logic signed [31:0] v [5];
    out_item_t s;
    v = '{p.point_x, p.point_y, p.point_heading, p.point_lin_speed, p.point_ang_speed};
    s = make_sample(idx, p.point_time, v);
    s.run_end = re;
    s.trajectory_end = te;
    return s;
  endfunction

  // Works out the samples a point causes and queues them; first gets the
  // earliest of them for the typed rows of the table.
  task automatic resample_point(in_item_t p, output out_item_t first);
    logic signed [31:0] v1 [5];
    logic signed [31:0] r [5];
    out_item_t batch [$];
    longint unsigned g, e, d, frac, mag, off;
    longint diff;
    v1 = '{p.point_x, p.point_y, p.point_heading, p.point_lin_speed, p.point_ang_speed};
    if (!in_traj) begin
      batch.push_back(make_sample(0, p.point_time, v1));
      in_traj = 1'b1;
      n_samples = 1;
    end else begin
      while (n_samples < MAX_SAMPLES) begin
        g = longint'(grid_period) * n_samples;
        if (!(longint'(p.point_time) > g)) break;
        if (g[31:0] <= last_time || p.point_time <= last_time) begin
          r = last_vals;
        end else begin
          e = g[31:0] - last_time;
          d = p.point_time - last_time;
          frac = (e << 32) / d;
          for (int j = 0; j < 5; j++) begin
            diff = longint'(v1[j]) - longint'(last_vals[j]);
            mag = (diff < 0) ? -diff : diff;
            off = (mag * frac) >> 32;
            r[j] = (diff < 0) ? last_vals[j] - off[31:0] : last_vals[j] + off[31:0];
          end
        end
        batch.push_back(make_sample(n_samples, g[31:0], r));
        n_samples++;
      end
    end
    last_time = p.point_time;
    last_vals = v1;
    if (p.final_point) begin
      if (n_samples >= MAX_SAMPLES) begin
        first = '0;
        first.status_code = STATUS_OVERFLOW;
        first.trajectory_end = 1'b1;
        batch.push_back(first);
      end else begin
        batch.push_back(copy_of(p, n_samples, 1'b0, 1'b1));
      end
      in_traj = 1'b0;
      n_samples = 0;
    end
    if (batch.size() > 0) begin
      batch[batch.size()-1].run_end = 1'b1;
      first = batch[0];
    end
    foreach (batch[i]) expected_samples.push_back(batch[i]);
  endtask

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic cmp_sample(out_item_t w, out_item_t a);
    cmp_field("sample_index", w.sample_index, a.sample_index);
    cmp_field("sample_time", w.sample_time, a.sample_time);
    cmp_field("sample_x", w.sample_x[31:0], a.sample_x[31:0]);
    cmp_field("sample_y", w.sample_y[31:0], a.sample_y[31:0]);
    cmp_field("sample_heading", w.sample_heading[31:0], a.sample_heading[31:0]);
    cmp_field("sample_lin_speed", w.sample_lin_speed[31:0], a.sample_lin_speed[31:0]);
    cmp_field("sample_ang_speed", w.sample_ang_speed[31:0], a.sample_ang_speed[31:0]);
    cmp_field("status_code", w.status_code, a.status_code);
    cmp_field("run_end", w.run_end, a.run_end);
    cmp_field("trajectory_end", w.trajectory_end, a.trajectory_end);
  endtask

  // offer one point and hold it until transferred
  task automatic send_point(in_item_t p, bit typed = 1'b0, out_item_t want = '0);
    int unsigned gap;
    out_item_t first;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    resample_point(p, first);
    if (typed) cmp_sample(want, first);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_period(logic [31:0] p);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
    grid_period = p;
  endtask

  // receiving side
  initial begin
    int unsigned hold;
    forever begin
      if (hold_req) begin
        hold = 3000;
        hold_req = 1'b0;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 3);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      if (expected_samples.size() == 0) begin
        $error("sample transferred with none expected");
        errors++;
      end else begin
        cmp_sample(expected_samples.pop_front(), out_data);
      end
    end
  end

  function automatic in_item_t rand_point(logic [31:0] t, bit fin);
    in_item_t p;
    p.point_time      = t;
    p.point_x         = $urandom;
    p.point_y         = $urandom;
    p.point_heading   = $urandom;
    p.point_lin_speed = $urandom;
    p.point_ang_speed = $urandom;
    p.final_point     = fin;
    return p;
  endfunction

  initial begin
    dir_row_t rows [$];
    in_item_t p;
    logic [31:0] periods [5];
    longint unsigned t;
    int unsigned len;

    grid_period = PERIOD_RESET;
    last_time = '0;
    last_vals = '{default: '0};
    n_samples = 0;
    in_traj = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, period 1.0 s after reset
    p = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 1'b0};
    rows.push_back('{p, 1'b1, copy_of(p, 0, 1'b1, 1'b0)});
    p = '{32'h3_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678, 32'h7fff_ffff,
          32'h8000_0000, 1'b0};
    rows.push_back('{p, 1'b0, '0});
    rows.push_back('{p ^ 1'b1, 1'b1, copy_of(p ^ 1'b1, 3, 1'b1, 1'b1)});
    p = '{32'h5_0000, 32'h10, 32'hffff_fff0, 32'h3, 32'h4, 32'h5, 1'b1};
    rows.push_back('{p, 1'b1, copy_of(p, 0, 1'b0, 1'b0)});
    p = '{32'hA_0000, 32'h1_0000, 32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h5_0000, 1'b0};
    rows.push_back('{p, 1'b1, copy_of(p, 0, 1'b1, 1'b0)});
    p = '{32'h2_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0};
    rows.push_back('{p, 1'b0, '0});
    p = '{32'h8_0000, 32'hffff_0000, 32'h0001_8000, 32'h7000_0000, 32'h9000_0000,
          32'h5555_5555, 1'b1};
    rows.push_back('{p, 1'b0, '0});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);
    drain();

    // sample limit: smallest period, overflow in place of the final sample
    set_period(32'h1);
    rows.delete();
    p = rand_point(32'h0, 1'b0);
    rows.push_back('{p, 1'b1, copy_of(p, 0, 1'b1, 1'b0)});
    rows.push_back('{rand_point(32'hffff_ffff, 1'b0), 1'b0, '0});
    rows.push_back('{rand_point(32'h0, 1'b0), 1'b0, '0});
    rows.push_back('{rand_point(32'h5, 1'b1), 1'b1,
                     '{7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                       STATUS_OVERFLOW, 1'b1, 1'b1}});
    foreach (rows[i]) send_point(rows[i].pt, rows[i].typed, rows[i].want);
    drain();

    // random trajectories over several grid periods
    periods = '{32'h1_0000, 32'hffff_ffff, 32'h1, 32'h0, 32'h0};
    periods[3] = $urandom_range(32'h1000, 32'h10_0000);
    periods[4] = $urandom_range(32'h10, 32'h4000_0000);
    hold_req = 1'b1;
    foreach (periods[ph]) begin
      set_period(periods[ph]);
      for (int items = 0; items < 80; ) begin
        if ($urandom_range(0, 9) == 0) calm = ~calm;
        len = $urandom_range(1, 8);
        t = $urandom_range(0, 3) == 0 ? $urandom : longint'($urandom_range(0, 3)) * periods[ph];
        for (int k = 0; k < len; k++) begin
          if (t > 32'hffff_ffff) t = 32'hffff_ffff;
          send_point(rand_point(t[31:0], k == len - 1));
          items++;
          case ($urandom_range(0, 9))
            0:       t = t;                        // equal time
            1:       t = $urandom;                 // arbitrary, often earlier
            default: t = t + (longint'(periods[ph]) * $urandom_range(0, 3000)) / 1000;
          endcase
        end
        if (ph == 2 && items > 40 && items < 50) drain();  // sender waits for all results
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0) begin
      $display("** constant_period_trajectory_resampler_core: PASSED **");
    end else begin
      $display("** constant_period_trajectory_resampler_core: FAILED **");
    end
    $finish;
  end

endmodule
